/* src/blzd_pkg.sv */
// shared types and constants for the backward lz bitstream decruncher
// no dependencies; imported by the controller, datapath and top level
package blzd_pkg;

   localparam int HISTORY_DEPTH = 32768;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);

   // request function codes
   localparam logic [1:0] FN_START = 2'd0;
   localparam logic [1:0] FN_PUSH  = 2'd1;
   localparam logic [1:0] FN_PULL  = 2'd2;

   // csr register indexes
   localparam logic [2:0] CSR_EFF0   = 3'd0;
   localparam logic [2:0] CSR_EFF1   = 3'd1;
   localparam logic [2:0] CSR_EFF2   = 3'd2;
   localparam logic [2:0] CSR_EFF3   = 3'd3;
   localparam logic [2:0] CSR_SKIP   = 3'd4;
   localparam logic [2:0] CSR_MASTER = 3'd5;
   localparam logic [2:0] CSR_OUTLEN = 3'd6;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_SRC_END  = 3'd1;
   localparam logic [2:0] ERR_OUT_OVF  = 3'd2;
   localparam logic [2:0] ERR_MATCH    = 3'd3;
   localparam logic [2:0] ERR_BUF_FULL = 3'd4;

   // field widths of the stream
   localparam logic [4:0] FLAG_BITS    = 5'd1;
   localparam logic [4:0] LIT_EXT_BITS = 5'd2;
   localparam logic [4:0] LIT_BITS     = 5'd8;
   localparam logic [4:0] SEL_BITS     = 5'd2;
   localparam logic [4:0] MEXT_BITS    = 5'd1;
   localparam logic [4:0] MLEN_BITS    = 5'd3;
   localparam logic [3:0] SHORT_OFF_W  = 4'd7;
   localparam logic [5:0] PUSH_LIMIT   = 6'd24;
   localparam logic [23:0] RUN_MAX     = 24'hFFFFFF;

   typedef enum logic [3:0] {
      PH_SKIP, PH_FLAG, PH_LITEXT, PH_LITBYTE, PH_MSEL, PH_MEXT,
      PH_MOFFS, PH_MOFFL, PH_MLEN, PH_MCOPY, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE, ST_EXEC, ST_COPYRD, ST_RESP
   } ctl_state_type;

   typedef enum logic [2:0] {
      RUN_HOLD, RUN_ONE, RUN_ADD, RUN_SEL, RUN_DEC
   } run_op_type;

   typedef enum logic [1:0] {
      OW_HOLD, OW_SEL, OW_SEVEN
   } ow_op_type;

   typedef struct packed {
      logic       clear_job;
      logic       push;
      logic       take;
      logic [4:0] take_n;
      logic       set_err;
      logic [2:0] err_code;
      logic       set_need;
      logic       rsp_clr;
      run_op_type run_op;
      ow_op_type  ow_op;
      logic       off_load;
      logic       emit_lit;
      logic       emit_copy;
      logic       hist_rd;
   } cmd_type;

   typedef struct packed {
      logic [5:0]  bits_held;
      logic [4:0]  skip_bits;
      logic [3:0]  offset_width;
      logic [14:0] field;
      logic        lit_flag;
      logic        bw_ge_len;
      logic        bw1_ge_len;
      logic        off_ge_bw;
      logic        field_ge_bw;
      logic        run_le1;
      logic        source_ended;
      logic        err_set;
   } status_type;

endpackage

/* src/blzd_dp.sv */
// datapath: csr registers, bit store, job counters, history memory, result register
// depends on blzd_pkg
module blzd_dp (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_data,
   input  logic [7:0]          src_byte,
   input  logic                src_last,
   input  blzd_pkg::cmd_type    cmd,
   output blzd_pkg::status_type stat,
   output logic [7:0]          out_byte,
   output logic                out_valid,
   output logic                need_source,
   output logic                done_res,
   output logic [2:0]          error_code
);
   import blzd_pkg::*;

   logic [3:0]  eff_ff [4];
   logic [4:0]  skip_ff;
   logic        master_ff;
   logic [23:0] outlen_ff;

   logic [31:0] store_ff, store_in;
   logic [5:0]  held_ff, held_in;
   logic [23:0] run_ff, run_in;
   logic [3:0]  ow_ff, ow_in;
   logic [14:0] off_ff;
   logic [23:0] bw_ff;
   logic        srcend_ff;
   logic [2:0]  err_ff;
   logic [7:0]  obyte_ff;
   logic        ovalid_ff, need_ff;

   logic [7:0]  hist_mem [HISTORY_DEPTH];
   logic [7:0]  hist_q;
   logic [HIST_AW-1:0] rd_addr;
   logic [23:0] rd_diff;
   logic [14:0] field;
   logic [24:0] run_sum;
   logic [23:0] run_add_val;
   logic [7:0]  emit_data;

   // msb-first assembly of the low bits taken from the store
   always_comb begin
      for (int i = 0; i < 15; i++) begin
         if (5'(i) < cmd.take_n) field[i] = store_ff[5'(cmd.take_n - 5'(i) - 5'd1)];
         else field[i] = 1'b0;
      end
   end

   assign run_sum     = {1'b0, run_ff} + {9'd0, field};
   assign run_add_val = run_sum[24] ? RUN_MAX : run_sum[23:0];
   assign rd_diff     = bw_ff - 24'd1 - {9'd0, off_ff};
   assign rd_addr     = rd_diff[HIST_AW-1:0];
   assign emit_data   = cmd.emit_copy ? hist_q : field[7:0];

   always_comb begin
      store_in = store_ff;
      held_in  = held_ff;
      if (cmd.push) begin
         store_in = store_ff | ({24'd0, src_byte} << held_ff);
         held_in  = held_ff + 6'd8;
      end else if (cmd.take) begin
         store_in = store_ff >> cmd.take_n;
         held_in  = held_ff - {1'b0, cmd.take_n};
      end
   end

   always_comb begin
      case (cmd.run_op)
         RUN_ONE: run_in = 24'd1;
         RUN_ADD: run_in = run_add_val;
         RUN_SEL: run_in = {22'd0, field[1:0]} + 24'd2;
         RUN_DEC: run_in = (run_ff != 24'd0) ? run_ff - 24'd1 : run_ff;
         default: run_in = run_ff;
      endcase
      case (cmd.ow_op)
         OW_SEL:   ow_in = eff_ff[field[1:0]];
         OW_SEVEN: ow_in = SHORT_OFF_W;
         default:  ow_in = ow_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff[0] <= 4'd9;
         eff_ff[1] <= 4'd10;
         eff_ff[2] <= 4'd12;
         eff_ff[3] <= 4'd13;
         skip_ff   <= 5'd0;
         master_ff <= 1'b0;
         outlen_ff <= 24'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_EFF0:   eff_ff[0] <= csr_data[3:0];
            CSR_EFF1:   eff_ff[1] <= csr_data[3:0];
            CSR_EFF2:   eff_ff[2] <= csr_data[3:0];
            CSR_EFF3:   eff_ff[3] <= csr_data[3:0];
            CSR_SKIP:   skip_ff   <= csr_data[4:0];
            CSR_MASTER: master_ff <= csr_data[0];
            CSR_OUTLEN: outlen_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_job) begin
         store_ff  <= 32'd0;
         held_ff   <= 6'd0;
         run_ff    <= 24'd0;
         ow_ff     <= 4'd0;
         off_ff    <= 15'd0;
         bw_ff     <= 24'd0;
         srcend_ff <= 1'b0;
         err_ff    <= ERR_NONE;
      end else begin
         store_ff <= store_in;
         held_ff  <= held_in;
         run_ff   <= run_in;
         ow_ff    <= ow_in;
         if (cmd.off_load) off_ff <= field;
         if (cmd.emit_lit || cmd.emit_copy) bw_ff <= bw_ff + 24'd1;
         if (cmd.push && src_last) srcend_ff <= 1'b1;
         if (cmd.set_err) err_ff <= cmd.err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.rsp_clr) begin
         ovalid_ff <= 1'b0;
         need_ff   <= 1'b0;
      end else begin
         if (cmd.emit_lit || cmd.emit_copy) ovalid_ff <= 1'b1;
         if (cmd.set_need) need_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_lit || cmd.emit_copy) begin
         obyte_ff <= emit_data;
         hist_mem[bw_ff[HIST_AW-1:0]] <= emit_data;
      end
      if (cmd.hist_rd) hist_q <= hist_mem[rd_addr];
   end

   assign stat.bits_held    = held_ff;
   assign stat.skip_bits    = skip_ff;
   assign stat.offset_width = ow_ff;
   assign stat.field        = field;
   assign stat.lit_flag     = (field[0] == master_ff);
   assign stat.bw_ge_len    = (bw_ff >= outlen_ff);
   assign stat.bw1_ge_len   = ({1'b0, bw_ff} + 25'd1 >= {1'b0, outlen_ff});
   assign stat.off_ge_bw    = ({9'd0, off_ff} >= bw_ff);
   assign stat.field_ge_bw  = ({9'd0, field} >= bw_ff);
   assign stat.run_le1      = (run_ff <= 24'd1);
   assign stat.source_ended = srcend_ff;
   assign stat.err_set      = (err_ff != ERR_NONE);

   assign out_byte    = (ovalid_ff && err_ff == ERR_NONE) ? obyte_ff : 8'd0;
   assign out_valid   = ovalid_ff && (err_ff == ERR_NONE);
   assign need_source = need_ff && (err_ff == ERR_NONE);
   assign done_res    = (bw_ff >= outlen_ff);
   assign error_code  = err_ff;

endmodule

/* src/blzd_ctrl.sv */
// controller: request sequencing and stream parse phase
// depends on blzd_pkg
module blzd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  blzd_pkg::status_type stat,
   output blzd_pkg::cmd_type    cmd
);
   import blzd_pkg::*;

   ctl_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SKIP;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      logic [4:0] n;
      logic       avail;
      state_in = state_ff;
      phase_in = phase_ff;
      cmd = '0;
      cmd.run_op = RUN_HOLD;
      cmd.ow_op  = OW_HOLD;
      case (phase_ff)
         PH_SKIP:              n = stat.skip_bits;
         PH_FLAG:              n = FLAG_BITS;
         PH_LITEXT:            n = LIT_EXT_BITS;
         PH_LITBYTE:           n = LIT_BITS;
         PH_MSEL:              n = SEL_BITS;
         PH_MEXT:              n = MEXT_BITS;
         PH_MOFFS, PH_MOFFL:   n = {1'b0, stat.offset_width};
         PH_MLEN:              n = MLEN_BITS;
         default:              n = 5'd0;
      endcase
      avail = ({1'b0, n} <= stat.bits_held);
      cmd.take_n = n;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.rsp_clr = 1'b1;
               state_in = ST_RESP;
               case (req_func)
                  FN_START: begin
                     cmd.clear_job = 1'b1;
                     phase_in = PH_SKIP;
                  end
                  FN_PUSH: begin
                     if (!stat.err_set && !stat.source_ended) begin
                        if (stat.bits_held > PUSH_LIMIT) begin
                           cmd.set_err  = 1'b1;
                           cmd.err_code = ERR_BUF_FULL;
                        end else begin
                           cmd.push = 1'b1;
                        end
                     end
                  end
                  FN_PULL: begin
                     if (!stat.err_set) state_in = ST_EXEC;
                  end
                  default: ;
               endcase
            end
         end
         ST_EXEC: begin
            if (phase_ff == PH_FLAG && stat.bw_ge_len) begin
               phase_in = PH_DONE;
            end else if (phase_ff == PH_MCOPY) begin
               cmd.hist_rd = 1'b1;
               state_in = ST_COPYRD;
            end else if (phase_ff == PH_DONE || phase_ff > PH_DONE) begin
               phase_in = PH_DONE;
               state_in = ST_RESP;
            end else if (!avail) begin
               // stall: out of bits
               if (stat.source_ended) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ERR_SRC_END;
               end else begin
                  cmd.set_need = 1'b1;
               end
               state_in = ST_RESP;
            end else begin
               cmd.take = 1'b1;
               case (phase_ff)
                  PH_SKIP: phase_in = PH_FLAG;
                  PH_FLAG: begin
                     if (stat.lit_flag) begin
                        cmd.run_op = RUN_ONE;
                        phase_in = PH_LITEXT;
                     end else begin
                        phase_in = PH_MSEL;
                     end
                  end
                  PH_LITEXT: begin
                     cmd.run_op = RUN_ADD;
                     if (stat.field[1:0] != 2'd3) phase_in = PH_LITBYTE;
                  end
                  PH_LITBYTE: begin
                     state_in = ST_RESP;
                     if (stat.bw_ge_len) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ERR_OUT_OVF;
                     end else begin
                        cmd.emit_lit = 1'b1;
                        cmd.run_op = RUN_DEC;
                        if (stat.run_le1) phase_in = stat.bw1_ge_len ? PH_DONE : PH_MSEL;
                     end
                  end
                  PH_MSEL: begin
                     cmd.ow_op  = OW_SEL;
                     cmd.run_op = RUN_SEL;
                     phase_in = (stat.field[1:0] == 2'd3) ? PH_MEXT : PH_MOFFS;
                  end
                  PH_MEXT: begin
                     if (!stat.field[0]) cmd.ow_op = OW_SEVEN;
                     phase_in = PH_MOFFL;
                  end
                  PH_MOFFS: begin
                     cmd.off_load = 1'b1;
                     if (stat.field_ge_bw) begin
                        cmd.set_err  = 1'b1;
                        cmd.err_code = ERR_MATCH;
                        state_in = ST_RESP;
                     end else begin
                        phase_in = PH_MCOPY;
                     end
                  end
                  PH_MOFFL: begin
                     cmd.off_load = 1'b1;
                     phase_in = PH_MLEN;
                  end
                  PH_MLEN: begin
                     cmd.run_op = RUN_ADD;
                     if (stat.field[2:0] != 3'd7) begin
                        if (stat.off_ge_bw) begin
                           cmd.set_err  = 1'b1;
                           cmd.err_code = ERR_MATCH;
                           state_in = ST_RESP;
                        end else begin
                           phase_in = PH_MCOPY;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_COPYRD: begin
            state_in = ST_RESP;
            if (stat.bw_ge_len) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = ERR_OUT_OVF;
            end else begin
               cmd.emit_copy = 1'b1;
               cmd.run_op = RUN_DEC;
               if (stat.run_le1) phase_in = PH_FLAG;
            end
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

/* src/backward_lz_bitstream_decruncher.sv */
// top level of the backward lz bitstream decruncher
// depends on blzd_pkg, blzd_ctrl and blzd_dp
//
// decrunches a backward lz77 bitstream one request at a time. a start request
// clears the job, a push adds one packed byte (fed from the end of the packed
// data toward its start) to a 32-bit bit store, and a pull returns at most one
// decompressed byte, last byte of the data first. every request gives exactly
// one result transfer. start, push and unused codes go from accepting the
// request straight to holding the result. a pull parses stream fields (skip,
// flag, run extension, literal byte, selector, match extension, offset,
// length) and ends on an emitted byte, a stall, an error or a job-done check.
// a match copy first reads the 32k x 8 history memory through its registered
// read port and then writes the copied byte. one request is in flight at a
// time: req_ready is high only while no result is pending. the history memory
// has no reset and needs no clearing pass. csr writes are always accepted and
// are meant to be made while the block is idle.
module backward_lz_bitstream_decruncher (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_src_byte,
   input  logic        req_src_last,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_valid,
   output logic        rsp_need_source,
   output logic        rsp_done_res,
   output logic [2:0]  rsp_error_code,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import blzd_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // register writes never stall
   assign csr_ready = 1'b1;

   // request sequencing and parse phase
   blzd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // bit store, counters, history and result register
   blzd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .src_byte    (req_src_byte),
      .src_last    (req_src_last),
      .cmd         (cmd),
      .stat        (stat),
      .out_byte    (rsp_out_byte),
      .out_valid   (rsp_out_valid),
      .need_source (rsp_need_source),
      .done_res    (rsp_done_res),
      .error_code  (rsp_error_code)
   );

endmodule
